/* rtl/first_fit_heap_allocator_defines.svh */
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off during reset.
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off during reset.
`define FFHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ffha_pkg.sv */
// Types, codes and constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int DATA_W           = 32;
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int CFG_IDX_W        = 1;
  localparam logic [DATA_W-1:0] HEAP_LIMIT_RST = 32'd65536;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2,
    OP_CALLOC = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOMEM   = 2'd2,
    ST_BADFREE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BASE  = 1'b0,
    CFG_HEAP_LIMIT = 1'b1
  } cfg_reg_e;

  // Request payload
  typedef struct packed {
    op_e               operation;
    logic [DATA_W-1:0] request_size;
    logic [DATA_W-1:0] element_count;
    logic [DATA_W-1:0] address;
  } req_t;

  // Response payload
  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] result_address;
    logic              copy_needed;
    logic [DATA_W-1:0] copy_source;
    logic [DATA_W-1:0] copy_length;
    logic              zero_fill;
  } rsp_t;

  // One block table entry
  typedef struct packed {
    logic              free;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] start;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Shared add/compare unit operands and results
  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              add_hdr;
    logic [DATA_W-1:0] c;
  } unit_in_t;

  typedef struct packed {
    logic [DATA_W+1:0] sum;
    logic              gt;
    logic              eq;
    logic              eq32;
  } unit_out_t;

endpackage

/* rtl/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator: sequencer, table and result register.
// Usage: requests (allocate, free, resize, zeroed allocate) arrive on in_valid_i /
// in_req_i and are taken when in_stall_o is low; one response per request leaves on
// out_valid_o / out_rsp_o and is taken when out_stall_i is low. The user must write
// heap_base and heap_limit on cfg_* only while no request is in flight (not enforced).
// Operation: the block table sits in a RAM with registered read, walked one entry at
// a time by a single add/compare unit: read in S_FIT_RD or S_FIND_RD, evaluated in
// S_FIT_EV or S_FIND_EV. Free walks to the matching entry, resize a lookup and, if it
// must move, a fit walk; zeroed allocate multiplies first. One request is worked at
// a time; in_stall_o is high until the response has moved into the output register.
// The output register lets the next request start while a response waits to be
// taken. A stalled response holds its value.
// Reset: the table is empty, heap top is 0, heap_limit is 65536; no clearing pass.
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  req_t                 in_req_i,
  // response channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rsp_t                 out_rsp_o,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_MUL_CHK,
    S_FIT_RD,
    S_FIT_EV,
    S_HIT,
    S_GROW,
    S_APPEND,
    S_FIND_RD,
    S_FIND_EV,
    S_RSZ_CHK,
    S_FREE_OLD,
    S_DONE
  } state_e;

  state_e                state_q;
  req_t                  req_q;
  rsp_t                  rsp_q;
  rsp_t                  out_q;
  logic                  out_valid_q;
  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      idx_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [IDX_W-1:0]      old_idx_q;
  logic [DATA_W-1:0]     top_q;
  logic [DATA_W-1:0]     limit_q;
  logic [DATA_W-1:0]     newtop_q;
  logic [DATA_W-1:0]     req_sz_q;
  logic [2*DATA_W-1:0]   prod_q;
  logic                  resize_q;
  logic                  zf_q;
  entry_t                ent_q;
  entry_t                old_q;

  logic                  ram_we;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                rd;
  entry_t                wr;
  unit_in_t              uin;
  unit_out_t             uout;
  logic                  is_alloc;
  logic                  size_ge;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign rd        = entry_t'(ram_rdata);
  assign ram_wdata = ENTRY_W'(wr);
  assign size_ge   = uout.gt | uout.eq;
  assign is_alloc  = (in_req_i.operation == OP_ALLOC) ||
                     ((in_req_i.operation == OP_RESIZE) && (in_req_i.address == '0));

  // block table
  ffha_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // shared add/compare unit
  ffha_alu #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_alu (
    .uin_i  (uin),
    .uout_o (uout)
  );

  // operand select and table write per state
  always_comb begin
    uin       = '0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_q[IDX_W-1:0];
    wr        = rd;
    case (state_q)
      S_FIT_RD, S_FIND_RD: begin
        ram_re = (idx_q < count_q);
      end
      S_FIT_EV: begin
        uin.a = rd.size;
        uin.c = req_sz_q;
      end
      S_HIT: begin
        uin.a       = ent_q.start;
        uin.add_hdr = 1'b1;
        ram_we      = 1'b1;
        ram_waddr   = hit_idx_q;
        wr          = '{free: 1'b0, size: ent_q.size, start: ent_q.start};
      end
      S_GROW: begin
        uin.a       = top_q;
        uin.b       = req_sz_q;
        uin.add_hdr = 1'b1;
        uin.c       = limit_q;
      end
      S_APPEND: begin
        uin.a       = top_q;
        uin.add_hdr = 1'b1;
        ram_we      = 1'b1;
        ram_waddr   = count_q[IDX_W-1:0];
        wr          = '{free: 1'b0, size: req_sz_q, start: top_q};
      end
      S_FIND_EV: begin
        uin.a       = rd.start;
        uin.add_hdr = 1'b1;
        uin.c       = req_q.address;
        // free of a live block marks it in place
        ram_we      = uout.eq32 && !rd.free && (req_q.operation == OP_FREE);
        wr          = '{free: 1'b1, size: rd.size, start: rd.start};
      end
      S_RSZ_CHK: begin
        uin.a = old_q.size;
        uin.c = req_q.request_size;
      end
      S_FREE_OLD: begin
        ram_we    = 1'b1;
        ram_waddr = old_idx_q;
        wr        = '{free: 1'b1, size: old_q.size, start: old_q.start};
      end
      default: begin
      end
    endcase
  end

  // sequencer, heap registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      rsp_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      hit_idx_q   <= '0;
      old_idx_q   <= '0;
      top_q       <= '0;
      limit_q     <= HEAP_LIMIT_RST;
      newtop_q    <= '0;
      req_sz_q    <= '0;
      prod_q      <= '0;
      resize_q    <= 1'b0;
      zf_q        <= 1'b0;
      ent_q       <= '0;
      old_q       <= '0;
    end else begin
      // response taken; a refill from S_DONE sets valid below
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      // configuration writes
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_HEAP_BASE: begin
            if (count_q == '0) begin
              top_q <= cfg_data_i;
            end
          end
          CFG_HEAP_LIMIT: limit_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q    <= in_req_i;
            idx_q    <= '0;
            resize_q <= 1'b0;
            zf_q     <= 1'b0;
            req_sz_q <= in_req_i.request_size;
            if (is_alloc) begin
              if (in_req_i.request_size == '0) begin
                rsp_q   <= '{status: ST_ZERO, default: '0};
                state_q <= S_DONE;
              end else begin
                rsp_q   <= '0;
                state_q <= S_FIT_RD;
              end
            end else if (in_req_i.operation == OP_CALLOC) begin
              rsp_q   <= '0;
              state_q <= S_MUL;
            end else if (in_req_i.address == '0) begin
              // free of none
              rsp_q   <= '0;
              state_q <= S_DONE;
            end else begin
              rsp_q   <= '0;
              state_q <= S_FIND_RD;
            end
          end
        end
        S_MUL: begin
          prod_q  <= (2 * DATA_W)'(req_q.element_count) * (2 * DATA_W)'(req_q.request_size);
          state_q <= S_MUL_CHK;
        end
        S_MUL_CHK: begin
          if (prod_q[2*DATA_W-1:DATA_W] != '0) begin
            rsp_q.status <= ST_NOMEM;
            state_q      <= S_DONE;
          end else if (prod_q[DATA_W-1:0] == '0) begin
            rsp_q.status <= ST_ZERO;
            state_q      <= S_DONE;
          end else begin
            req_sz_q <= prod_q[DATA_W-1:0];
            zf_q     <= 1'b1;
            state_q  <= S_FIT_RD;
          end
        end
        // first-fit walk
        S_FIT_RD: begin
          state_q <= (idx_q < count_q) ? S_FIT_EV : S_GROW;
        end
        S_FIT_EV: begin
          if (rd.free && size_ge) begin
            ent_q     <= rd;
            hit_idx_q <= idx_q[IDX_W-1:0];
            state_q   <= S_HIT;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_FIT_RD;
          end
        end
        S_HIT, S_APPEND: begin
          if (state_q == S_APPEND) begin
            count_q <= count_q + 1'b1;
            top_q   <= newtop_q;
          end
          rsp_q.result_address <= uout.sum[DATA_W-1:0];
          rsp_q.zero_fill      <= zf_q;
          rsp_q.copy_needed    <= resize_q;
          rsp_q.copy_source    <= resize_q ? req_q.address : '0;
          rsp_q.copy_length    <= resize_q ? old_q.size : '0;
          state_q              <= resize_q ? S_FREE_OLD : S_DONE;
        end
        // growth at the heap top
        S_GROW: begin
          if ((count_q == CNT_FULL) || uout.gt) begin
            rsp_q.status <= ST_NOMEM;
            state_q      <= S_DONE;
          end else begin
            newtop_q <= uout.sum[DATA_W-1:0];
            state_q  <= S_APPEND;
          end
        end
        // address lookup for free and resize
        S_FIND_RD: begin
          if (idx_q < count_q) begin
            state_q <= S_FIND_EV;
          end else begin
            rsp_q.status <= ST_BADFREE;
            state_q      <= S_DONE;
          end
        end
        S_FIND_EV: begin
          if (uout.eq32) begin
            if (rd.free) begin
              rsp_q.status <= ST_BADFREE;
              state_q      <= S_DONE;
            end else if (req_q.operation == OP_FREE) begin
              state_q <= S_DONE;
            end else begin
              old_q     <= rd;
              old_idx_q <= idx_q[IDX_W-1:0];
              state_q   <= S_RSZ_CHK;
            end
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_FIND_RD;
          end
        end
        S_RSZ_CHK: begin
          if (size_ge) begin
            rsp_q.result_address <= req_q.address;
            state_q              <= S_DONE;
          end else begin
            resize_q <= 1'b1;
            idx_q    <= '0;
            state_q  <= S_FIT_RD;
          end
        end
        S_FREE_OLD: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= rsp_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  `FFHA_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_FULL,
                   "block count above table depth")
  `FFHA_ASSERT_NXT(a_count_only_append, state_q != S_APPEND, $stable(count_q),
                   "block count changed outside an append")
  `FFHA_ASSERT_NXT(a_top_in_limit, state_q == S_APPEND, top_q <= limit_q,
                   "heap top grew past the limit")
  `FFHA_ASSERT_IMP(a_copy_is_ok, out_valid_q && out_q.copy_needed,
                   (out_q.status == ST_OK) && !out_q.zero_fill,
                   "copy reported on a failed or zeroed request")

endmodule

/* rtl/ffha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ffha_alu.sv */
// Shared adder and comparator: sum = a + b (+ header), compared against c.
module ffha_alu
  import ffha_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  unit_in_t  uin_i,
  output unit_out_t uout_o
);

  localparam logic [DATA_W+1:0] HDR = (DATA_W + 2)'(HEADER_BYTES);

  logic [DATA_W+1:0] sum;
  logic [DATA_W+1:0] cmp;

  // three-input add, wide enough that no carry is lost
  assign sum = {2'b00, uin_i.a} + {2'b00, uin_i.b} + (uin_i.add_hdr ? HDR : '0);
  assign cmp = {2'b00, uin_i.c};

  assign uout_o.sum  = sum;
  assign uout_o.gt   = (sum > cmp);
  assign uout_o.eq   = (sum == cmp);
  assign uout_o.eq32 = (sum[DATA_W-1:0] == uin_i.c);

endmodule
